// ===== sv/kmcc_pkg.sv =====
// Shared types, constants and register codes for the knob-to-MIDI CC controller.
`timescale 1ns / 1ps
`default_nettype none

package kmcc_pkg;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 42;
	localparam int QUEUE_DEPTH_DEFAULT = 4;

	localparam logic [CFG_INDEX_W-1:0] REG_MODE_FLAGS          = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_MIDI_CHANNELS       = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_CONTROL_NUMBERS     = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_BUTTON_VALUES       = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_ROTATION_DELTAS     = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_RELATIVE_ZERO_POINT = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_ACCELERATION        = 3'd6;

	localparam int MODE_BTN_EXT       = 0;
	localparam int MODE_BTN_MOMENTARY = 1;
	localparam int MODE_ROT_EXT       = 2;
	localparam int MODE_ROT_RELATIVE  = 3;
	localparam int MODE_ROT_REVERSE   = 4;

	localparam logic [13:0] LIMIT_FOURTEEN   = 14'h3fff;
	localparam logic [6:0]  LIMIT_SEVEN      = 7'h7f;
	localparam logic [5:0]  IDLE_HALVE_TICKS = 6'd50;
	localparam logic [6:0]  ZERO_POINT_RESET = 7'd64;

	typedef struct packed {
		logic [4:0]  mode_flags;
		logic [7:0]  midi_channels;
		logic [27:0] control_numbers;
		logic [41:0] button_values;
		logic [31:0] rotation_deltas;
		logic [6:0]  relative_zero_point;
		logic [7:0]  acceleration;
	} cfg_t;

	typedef struct packed {
		logic        btn_send;
		logic        use_b;
		logic        step;
		logic [31:0] product;
	} cmd_t;

	typedef struct packed {
		logic [3:0] ch;
		logic [6:0] num;
		logic [6:0] val;
	} pkt_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

`default_nettype wire

// ===== sv/kmcc_front.sv =====
// Front end: input transfer, button debounce, velocity tracking and step product.
`timescale 1ns / 1ps
`default_nettype none

module kmcc_front (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  wire                 tick,
	input  wire                 button_level,
	input  wire  signed [1:0]   step_direction,
	input  wire kmcc_pkg::cfg_t    cfg,
	input  wire kmcc_pkg::q_stat_t q_stat,
	output logic                q_push,
	output kmcc_pkg::cmd_t      q_cmd
);
	import kmcc_pkg::*;

	logic               deb_level_q;
	logic [1:0]         deb_ticks_q;
	logic               toggle_q;
	logic [13:0]        vel_q;
	logic [5:0]         idle_q;

	logic               accept;
	logic               lvl_chg;
	logic               pressed;
	logic               released;
	logic [1:0]         deb_base;
	logic [1:0]         deb_ticks_d;
	logic [5:0]         idle_inc;
	logic [5:0]         idle_d;
	logic               toggle_d;
	logic               btn_send;
	logic               use_b;
	logic               step;
	logic               rot_ext;
	logic               neg;
	logic [15:0]        d_raw;
	logic [15:0]        d_sel;
	logic [14:0]        vel_inc;
	logic signed [31:0] product;
	logic [13:0]        limit;
	logic [14:0]        vel_sum;
	logic [13:0]        vel_d;

	assign in_ready = !q_stat.full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		lvl_chg  = (button_level != deb_level_q) && (deb_ticks_q > 2'd1);
		pressed  = lvl_chg && button_level;
		released = lvl_chg && !button_level;
		deb_base = lvl_chg ? 2'd0 : deb_ticks_q;
		deb_ticks_d = (tick && deb_base <= 2'd2) ? deb_base + 2'd1 : deb_base;
		idle_inc = tick ? idle_q + 6'd1 : idle_q;
		toggle_d = toggle_q ^ pressed;
		btn_send = pressed || (released && cfg.mode_flags[MODE_BTN_MOMENTARY]);
		use_b    = pressed ? (!cfg.mode_flags[MODE_BTN_MOMENTARY] && toggle_d) : 1'b1;

		step    = step_direction != 2'sd0;
		rot_ext = cfg.mode_flags[MODE_ROT_EXT];
		neg     = step_direction[1] ^ cfg.mode_flags[MODE_ROT_REVERSE];
		d_raw   = rot_ext ? cfg.rotation_deltas[31:16] : cfg.rotation_deltas[15:0];
		d_sel   = neg ? (~d_raw + 16'd1) : d_raw;
		vel_inc = {1'b0, vel_q} + 15'd1;
		limit   = rot_ext ? LIMIT_FOURTEEN : {7'd0, LIMIT_SEVEN};
		vel_sum = {1'b0, vel_q} + {7'd0, cfg.acceleration};

		if (step) begin
			vel_d  = (vel_sum >= {1'b0, limit}) ? limit : vel_sum[13:0];
			idle_d = 6'd0;
		end else if (idle_inc == IDLE_HALVE_TICKS) begin
			vel_d  = vel_q >> 1;
			idle_d = 6'd0;
		end else begin
			vel_d  = vel_q;
			idle_d = idle_inc;
		end
	end

	assign product = $signed(d_sel) * $signed({1'b0, vel_inc});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deb_level_q <= 1'b0;
			deb_ticks_q <= 2'd0;
			toggle_q    <= 1'b0;
			vel_q       <= 14'd0;
			idle_q      <= 6'd0;
		end else if (accept) begin
			if (lvl_chg) begin
				deb_level_q <= button_level;
			end
			deb_ticks_q <= deb_ticks_d;
			toggle_q    <= toggle_d;
			vel_q       <= vel_d;
			idle_q      <= idle_d;
		end
	end

	assign q_push        = accept && (btn_send || step);
	assign q_cmd.btn_send = btn_send;
	assign q_cmd.use_b    = use_b;
	assign q_cmd.step     = step;
	assign q_cmd.product  = product;

endmodule

`default_nettype wire

// ===== sv/kmcc_queue.sv =====
// Command queue between the front end and the packet back end.
`timescale 1ns / 1ps
`default_nettype none

module kmcc_queue #(
	parameter int DEPTH = kmcc_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	input  wire kmcc_pkg::cmd_t wr_cmd,
	input  wire                 pop,
	output kmcc_pkg::cmd_t      rd_cmd,
	output kmcc_pkg::q_stat_t   stat
);
	import kmcc_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t          mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign stat.full  = count_q == CW'(DEPTH);
	assign stat.empty = count_q == '0;
	assign rd_cmd     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/kmcc_back.sv =====
// Back end: rotation value update, packet list build and packet output.
`timescale 1ns / 1ps
`default_nettype none

module kmcc_back (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire kmcc_pkg::cfg_t    cfg,
	input  wire kmcc_pkg::q_stat_t q_stat,
	input  wire kmcc_pkg::cmd_t    q_cmd,
	output logic                q_pop,
	output logic                out_valid,
	input  wire                 out_ready,
	output logic [3:0]          midi_channel,
	output logic [6:0]          control_number,
	output logic [6:0]          control_value,
	output logic                last_packet
);
	import kmcc_pkg::*;

	logic        job_valid_q;
	logic [1:0]  job_idx_q;
	logic [1:0]  job_last_q;
	pkt_t        pkt_q [4];
	logic [6:0]  value_seven_q;
	logic [13:0] value_fourteen_q;

	logic               xfer;
	logic               load;
	logic               bext;
	logic               rot_ext;
	logic               rel;
	logic [13:0]        bval;
	logic [3:0]         bch;
	logic [3:0]         rch;
	pkt_t               b_hi;
	pkt_t               b_lo;
	pkt_t               r_hi;
	pkt_t               r_lo;
	logic [2:0]         b_n;
	logic [2:0]         r_n;
	logic [2:0]         total;
	logic [13:0]        limit;
	logic [13:0]        cur_base;
	logic signed [32:0] sum;
	logic [13:0]        cur;
	logic [6:0]         rval;
	pkt_t               p [4];

	assign xfer  = out_valid && out_ready;
	assign load  = !job_valid_q || (xfer && last_packet);
	assign q_pop = load && !q_stat.empty;

	always_comb begin
		bext    = cfg.mode_flags[MODE_BTN_EXT];
		rot_ext = cfg.mode_flags[MODE_ROT_EXT];
		rel     = cfg.mode_flags[MODE_ROT_RELATIVE];
		bch     = cfg.midi_channels[3:0];
		rch     = cfg.midi_channels[7:4];

		if (bext) begin
			bval = q_cmd.use_b ? cfg.button_values[41:28] : cfg.button_values[27:14];
		end else begin
			bval = {7'd0, q_cmd.use_b ? cfg.button_values[13:7] : cfg.button_values[6:0]};
		end
		b_hi = {bch, cfg.control_numbers[6:0], bext ? bval[13:7] : bval[6:0]};
		b_lo = {bch, cfg.control_numbers[13:7], bval[6:0]};
		b_n  = !q_cmd.btn_send ? 3'd0 : (bext ? 3'd2 : 3'd1);

		limit    = rot_ext ? LIMIT_FOURTEEN : {7'd0, LIMIT_SEVEN};
		cur_base = rot_ext ? value_fourteen_q : {7'd0, value_seven_q};
		sum      = $signed({19'd0, cur_base}) + $signed({q_cmd.product[31], q_cmd.product});
		if (sum[32]) begin
			cur = 14'd0;
		end else if (sum[31:0] > {18'd0, limit}) begin
			cur = limit;
		end else begin
			cur = sum[13:0];
		end
		rval = cfg.relative_zero_point + q_cmd.product[6:0];

		if (rel) begin
			r_hi = {rch, cfg.control_numbers[20:14], rval};
		end else begin
			r_hi = {rch, cfg.control_numbers[20:14], rot_ext ? cur[13:7] : cur[6:0]};
		end
		r_lo = {rch, cfg.control_numbers[27:21], cur[6:0]};
		r_n  = !q_cmd.step ? 3'd0 : ((rel || !rot_ext) ? 3'd1 : 3'd2);

		total = b_n + r_n;
		p[0]  = (b_n != 3'd0) ? b_hi : r_hi;
		p[1]  = (b_n == 3'd2) ? b_lo : ((b_n == 3'd1) ? r_hi : r_lo);
		p[2]  = (b_n == 3'd2) ? r_hi : r_lo;
		p[3]  = r_lo;
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			for (int i = 0; i < 4; i++) begin
				pkt_q[i] <= p[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_q      <= 1'b0;
			job_idx_q        <= 2'd0;
			job_last_q       <= 2'd0;
			value_seven_q    <= 7'd0;
			value_fourteen_q <= 14'd0;
		end else if (q_pop) begin
			job_valid_q <= 1'b1;
			job_idx_q   <= 2'd0;
			job_last_q  <= 2'(total - 3'd1);
			if (q_cmd.step && !rel) begin
				if (rot_ext) begin
					value_fourteen_q <= cur;
				end else begin
					value_seven_q <= cur[6:0];
				end
			end
		end else if (load) begin
			job_valid_q <= 1'b0;
		end else if (xfer) begin
			job_idx_q <= job_idx_q + 2'd1;
		end
	end

	assign out_valid      = job_valid_q;
	assign midi_channel   = pkt_q[job_idx_q].ch;
	assign control_number = pkt_q[job_idx_q].num;
	assign control_value  = pkt_q[job_idx_q].val;
	assign last_packet    = job_idx_q == job_last_q;

endmodule

`default_nettype wire

// ===== sv/knob_to_midi_cc_controller.sv =====
// Top level of the knob-to-MIDI control-change controller.
`timescale 1ns / 1ps
`default_nettype none

// Turns encoder steps and button samples into MIDI control-change packets, one
// packet per output transfer, with last_packet set on the final packet of each
// input. An input is accepted whenever the command queue has room; inputs that
// cause no packet only update debounce, idle and velocity state. While out_ready
// is held high the back end sends one packet per cycle; an input yields between
// one and four packets (two per value in extended mode, but one for a relative
// rotation), and that packet count sets the sustained rate. The first packet of
// an input is presented once its command has passed the queue, written at the
// input transfer, and the packet registers fed by the clamp and packet build.
// Write configuration registers only while no packets are pending.
module knob_to_midi_cc_controller #(
	parameter int QUEUE_DEPTH = kmcc_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                cfg_we,
	input  wire  [kmcc_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  wire  [kmcc_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  wire                                in_valid,
	output logic                               in_ready,
	input  wire                                tick,
	input  wire                                button_level,
	input  wire  signed [1:0]                  step_direction,
	output logic                               out_valid,
	input  wire                                out_ready,
	output logic [3:0]                         midi_channel,
	output logic [6:0]                         control_number,
	output logic [6:0]                         control_value,
	output logic                               last_packet
);
	import kmcc_pkg::*;

	cfg_t    cfg_q;
	q_stat_t q_stat;
	cmd_t    push_cmd;
	cmd_t    pop_cmd;
	logic    q_push;
	logic    q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode_flags          <= '0;
			cfg_q.midi_channels       <= '0;
			cfg_q.control_numbers     <= '0;
			cfg_q.button_values       <= '0;
			cfg_q.rotation_deltas     <= '0;
			cfg_q.relative_zero_point <= ZERO_POINT_RESET;
			cfg_q.acceleration        <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODE_FLAGS:          cfg_q.mode_flags          <= cfg_data[4:0];
				REG_MIDI_CHANNELS:       cfg_q.midi_channels       <= cfg_data[7:0];
				REG_CONTROL_NUMBERS:     cfg_q.control_numbers     <= cfg_data[27:0];
				REG_BUTTON_VALUES:       cfg_q.button_values       <= cfg_data[41:0];
				REG_ROTATION_DELTAS:     cfg_q.rotation_deltas     <= cfg_data[31:0];
				REG_RELATIVE_ZERO_POINT: cfg_q.relative_zero_point <= cfg_data[6:0];
				REG_ACCELERATION:        cfg_q.acceleration        <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	kmcc_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.tick           (tick),
		.button_level   (button_level),
		.step_direction (step_direction),
		.cfg            (cfg_q),
		.q_stat         (q_stat),
		.q_push         (q_push),
		.q_cmd          (push_cmd)
	);

	kmcc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wr_cmd (push_cmd),
		.pop    (q_pop),
		.rd_cmd (pop_cmd),
		.stat   (q_stat)
	);

	kmcc_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.q_stat         (q_stat),
		.q_cmd          (pop_cmd),
		.q_pop          (q_pop),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.midi_channel   (midi_channel),
		.control_number (control_number),
		.control_value  (control_value),
		.last_packet    (last_packet)
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_push && q_stat.full))
		else $error("command queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_pop && q_stat.empty))
		else $error("command queue read while empty");

	a_drain_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && last_packet && q_stat.empty) |=> !out_valid)
		else $error("packet shown with no command pending");

endmodule

`default_nettype wire
